// ===== rtl/core/lldc_pkg.sv =====
// Package for the linked list deque with cursor.
// Operation and status codes, controller states and the command/status structs.
package lldc_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_REWIND     = 3'd4,
    OP_NEXT       = 3'd5,
    OP_GET        = 3'd6,
    OP_REMOVE     = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_CURSOR = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ1,
    S_WAIT1,
    S_READ2,
    S_WRITE,
    S_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;  // latch operation and payload, run checks
    logic rd1;    // read links of the primary entry
    logic rd2;    // latch links of the primary entry
    logic commit; // do the memory writes and register updates
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fail;     // the operation ends without touching the list
    logic need_rd;  // the operation needs the links of an existing entry
  } sts_t;

endpackage

// ===== rtl/core/lldc_ctrl.sv =====
// Controller state machine of the linked list deque.
// Depends on lldc_pkg.
module lldc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lldc_pkg::sts_t    sts_i,
  output lldc_pkg::cmd_t    cmd_o
);

  lldc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lldc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      lldc_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = lldc_pkg::S_READ1;
        end
      end
      lldc_pkg::S_READ1: begin
        if (sts_i.fail) begin
          state_d = lldc_pkg::S_OUT;
        end else if (sts_i.need_rd) begin
          cmd_o.rd1 = 1'b1;
          state_d   = lldc_pkg::S_WAIT1;
        end else begin
          state_d = lldc_pkg::S_WRITE;
        end
      end
      lldc_pkg::S_WAIT1: begin
        state_d = lldc_pkg::S_READ2;
      end
      lldc_pkg::S_READ2: begin
        cmd_o.rd2 = 1'b1;
        state_d   = lldc_pkg::S_WRITE;
      end
      lldc_pkg::S_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d      = lldc_pkg::S_OUT;
      end
      lldc_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = lldc_pkg::S_IDLE;
        end
      end
      default: state_d = lldc_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/lldc_dp.sv =====
// Datapath of the linked list deque: entry memories, list registers, result.
// Depends on lldc_pkg.
module lldc_dp #(
  parameter int unsigned DEPTH         = 256,
  parameter int unsigned PAYLOAD_WIDTH = 32,
  parameter int unsigned IW            = $clog2(DEPTH + 1),
  parameter int unsigned AW            = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [2:0]               operation_i,
  input  logic [PAYLOAD_WIDTH-1:0] payload_i,
  input  lldc_pkg::cmd_t           cmd_i,
  output lldc_pkg::sts_t           sts_o,
  output logic [PAYLOAD_WIDTH-1:0] payload_out_o,
  output logic [1:0]               status_o,
  output logic [IW-1:0]            count_o,
  output logic                     cursor_valid_o
);

  localparam logic [IW-1:0] NULL_IDX = IW'(DEPTH);

  logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];
  logic [IW-1:0]            next_mem [DEPTH];
  logic [IW-1:0]            prev_mem [DEPTH];

  logic [IW-1:0] head_q, tail_q, cnt_q, cur_q, free_q, fresh_q;
  lldc_pkg::op_e op_q;
  logic [PAYLOAD_WIDTH-1:0] pin_q, pout_q;
  logic [1:0] st_q;
  logic       fail_q;
  logic [IW-1:0] e_q;      // primary entry
  logic [IW-1:0] rn_q, rp_q; // read data of primary entry
  logic [PAYLOAD_WIDTH-1:0] rpay_q;
  logic [IW-1:0] ln_q, lp_q; // latched links

  function automatic logic live(input logic [IW-1:0] i);
    return i < NULL_IDX;
  endfunction

  // Checks on the live state, at start.
  logic          chk_fail;
  logic [1:0]    chk_st;
  logic [IW-1:0] chk_e;
  logic          full;
  lldc_pkg::op_e op_in;
  assign op_in = lldc_pkg::op_e'(operation_i);
  assign full  = !live(free_q) && (fresh_q == NULL_IDX);

  always_comb begin
    chk_fail = 1'b0;
    chk_st   = lldc_pkg::ST_OK;
    chk_e    = cur_q;
    unique case (op_in)
      lldc_pkg::OP_PUSH_FRONT, lldc_pkg::OP_PUSH_BACK: begin
        chk_e = live(free_q) ? free_q : fresh_q;
        if (full) begin
          chk_fail = 1'b1;
          chk_st   = lldc_pkg::ST_FULL;
        end
      end
      lldc_pkg::OP_POP_FRONT, lldc_pkg::OP_POP_BACK: begin
        chk_e = (op_in == lldc_pkg::OP_POP_FRONT) ? head_q : tail_q;
        if (cnt_q == '0) begin
          chk_fail = 1'b1;
          chk_st   = lldc_pkg::ST_EMPTY;
        end
      end
      lldc_pkg::OP_REWIND: begin
        chk_fail = 1'b1;
        if (cnt_q == '0) chk_st = lldc_pkg::ST_EMPTY;
      end
      default: begin
        if (cnt_q == '0) begin
          chk_fail = 1'b1;
          chk_st   = lldc_pkg::ST_EMPTY;
        end else if (!live(cur_q)) begin
          chk_fail = 1'b1;
          chk_st   = lldc_pkg::ST_CURSOR;
        end
      end
    endcase
  end

  assign sts_o.fail    = fail_q;
  assign sts_o.need_rd = !((op_q == lldc_pkg::OP_PUSH_FRONT) ||
                           (op_q == lldc_pkg::OP_PUSH_BACK)) || live(free_q);

  // Memory read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd1) begin
      rn_q   <= next_mem[e_q[AW-1:0]];
      rp_q   <= prev_mem[e_q[AW-1:0]];
      rpay_q <= pay_mem[e_q[AW-1:0]];
    end
  end

  // Commit: compute writes.
  logic          wn_en, wp_en, wn2_en, wp2_en, wpay_en;
  logic [IW-1:0] wn_a, wn_d, wp_a, wp_d, wn2_a, wn2_d, wp2_a, wp2_d;
  logic [IW-1:0] head_d, tail_d, cnt_d, cur_d, free_d, fresh_d;
  logic [PAYLOAD_WIDTH-1:0] pout_d;
  logic [1:0]    st_d;
  logic          is_one;

  assign is_one = (cnt_q == IW'(1));

  always_comb begin
    wn_en = 1'b0; wp_en = 1'b0; wn2_en = 1'b0; wp2_en = 1'b0; wpay_en = 1'b0;
    wn_a = e_q; wn_d = NULL_IDX; wp_a = e_q; wp_d = NULL_IDX;
    wn2_a = ln_q; wn2_d = NULL_IDX; wp2_a = ln_q; wp2_d = NULL_IDX;
    head_d = head_q; tail_d = tail_q; cnt_d = cnt_q; cur_d = cur_q;
    free_d = free_q; fresh_d = fresh_q; pout_d = '0; st_d = lldc_pkg::ST_OK;
    unique case (op_q)
      lldc_pkg::OP_PUSH_FRONT, lldc_pkg::OP_PUSH_BACK: begin
        wpay_en = 1'b1; wn_en = 1'b1; wp_en = 1'b1;
        if (live(free_q)) free_d = ln_q;
        else fresh_d = fresh_q + IW'(1);
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == '0) begin
          head_d = e_q; tail_d = e_q;
        end else if (op_q == lldc_pkg::OP_PUSH_FRONT) begin
          wn_d = head_q;
          wp2_en = 1'b1; wp2_a = head_q; wp2_d = e_q;
          head_d = e_q;
        end else begin
          wp_d = tail_q;
          wn2_en = 1'b1; wn2_a = tail_q; wn2_d = e_q;
          tail_d = e_q;
        end
      end
      lldc_pkg::OP_POP_FRONT, lldc_pkg::OP_POP_BACK: begin
        pout_d = rpay_q;
        if (is_one) begin
          head_d = NULL_IDX; tail_d = NULL_IDX;
        end else if (op_q == lldc_pkg::OP_POP_FRONT) begin
          head_d = ln_q;
          wp2_en = live(ln_q); wp2_a = ln_q; wp2_d = NULL_IDX;
        end else begin
          tail_d = lp_q;
          wn2_en = live(lp_q); wn2_a = lp_q; wn2_d = NULL_IDX;
        end
        if (cur_q == e_q) cur_d = NULL_IDX;
        cnt_d = cnt_q - IW'(1);
        wn_en = 1'b1; wn_d = free_q; free_d = e_q;
      end
      lldc_pkg::OP_NEXT: begin
        cur_d = ln_q;
        if (!live(ln_q)) st_d = lldc_pkg::ST_CURSOR;
      end
      lldc_pkg::OP_GET: begin
        pout_d = rpay_q;
      end
      lldc_pkg::OP_REMOVE: begin
        if (is_one) begin
          head_d = NULL_IDX; tail_d = NULL_IDX; cur_d = NULL_IDX;
        end else if (!live(lp_q)) begin
          head_d = ln_q; cur_d = ln_q;
          wp2_en = live(ln_q); wp2_a = ln_q; wp2_d = NULL_IDX;
        end else if (!live(ln_q)) begin
          tail_d = lp_q; cur_d = lp_q;
          wn2_en = 1'b1; wn2_a = lp_q; wn2_d = NULL_IDX;
        end else begin
          wn2_en = 1'b1; wn2_a = lp_q; wn2_d = ln_q;
          wp2_en = 1'b1; wp2_a = ln_q; wp2_d = lp_q;
          cur_d = ln_q;
        end
        cnt_d = cnt_q - IW'(1);
        wn_en = 1'b1; wn_d = free_q; free_d = e_q;
      end
      default: ;
    endcase
  end

  // Memory writes. At most two next and two prev writes at distinct
  // addresses, so each link store is written at two ports in the same cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (wpay_en) pay_mem[e_q[AW-1:0]] <= pin_q;
      if (wn_en)   next_mem[wn_a[AW-1:0]] <= wn_d;
      if (wn2_en)  next_mem[wn2_a[AW-1:0]] <= wn2_d;
      if (wp_en)   prev_mem[wp_a[AW-1:0]] <= wp_d;
      if (wp2_en)  prev_mem[wp2_a[AW-1:0]] <= wp2_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_in;
      pin_q <= payload_i;
      e_q   <= chk_e;
    end
    if (cmd_i.rd2) begin
      ln_q <= rn_q;
      lp_q <= rp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= NULL_IDX;
      tail_q  <= NULL_IDX;
      cnt_q   <= '0;
      cur_q   <= NULL_IDX;
      free_q  <= NULL_IDX;
      fresh_q <= '0;
      fail_q  <= 1'b0;
      st_q    <= lldc_pkg::ST_OK;
      pout_q  <= '0;
    end else begin
      if (cmd_i.start) begin
        fail_q <= chk_fail;
        st_q   <= chk_st;
        pout_q <= '0;
        if (op_in == lldc_pkg::OP_REWIND) cur_q <= head_q;
      end
      if (cmd_i.commit) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        cnt_q   <= cnt_d;
        cur_q   <= cur_d;
        free_q  <= free_d;
        fresh_q <= fresh_d;
        st_q    <= st_d;
        pout_q  <= pout_d;
      end
    end
  end

  assign payload_out_o  = pout_q;
  assign status_o       = st_q;
  assign count_o        = cnt_q;
  assign cursor_valid_o = live(cur_q);

endmodule

// ===== rtl/core/linked_list_deque_with_cursor_core.sv =====
// Top level of the linked list deque with cursor.
// Joins lldc_ctrl and lldc_dp; depends on lldc_pkg.
//
// Usage:
//  - Input channel in_valid_i/in_stall_o carries operation_i and payload_i.
//    One transfer is one operation: push/pop front or back, rewind, next,
//    get, remove at the cursor.
//  - Output channel out_valid_o/out_stall_i carries payload_out_o,
//    status_o, count_o and cursor_valid_o, one result per operation.
//  - Order: a check that fails, and rewind, go from the checks straight
//    to the result; pushes that take a never-used entry write, then give
//    the result; when the links of an entry are read (pops, next, get,
//    remove, pushes from the free list), the registered memory read, a
//    wait state and the latch of the links come before the writes.
//  - One operation at a time: a new input is taken only once the result
//    has been transferred.
//  - Reset empties the list and clears the cursor; the entry memories hold
//    no reset value and are only read after being written.
//  - A stalled result holds its value until transferred.
module linked_list_deque_with_cursor_core #(
  parameter int unsigned DEPTH         = 256,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    operation_i,
  input  logic [PAYLOAD_WIDTH-1:0]      payload_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [PAYLOAD_WIDTH-1:0]      payload_out_o,
  output logic [1:0]                    status_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o,
  output logic                          cursor_valid_o
);

  lldc_pkg::cmd_t cmd;
  lldc_pkg::sts_t sts;

  lldc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lldc_dp #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .payload_i      (payload_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .payload_out_o  (payload_out_o),
    .status_o       (status_o),
    .count_o        (count_o),
    .cursor_valid_o (cursor_valid_o)
  );

endmodule

// ===== rtl/core/lldc_checker.sv =====
// Port checker for the linked list deque with cursor, bound to the top level.
// Depends on nothing beyond the top level's ports.
module lldc_checker #(
  parameter int unsigned CW = 9
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input logic [1:0]    status_o,
  input logic [CW-1:0] count_o,
  input logic          cursor_valid_o
);

  // Result held while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(count_o))
    else $error("result changed while stalled");

  // No input taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  // An empty list never shows a valid cursor.
  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (count_o == '0) |-> !cursor_valid_o)
    else $error("cursor valid on empty list");

  // An accepted input yields no result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

endmodule

bind linked_list_deque_with_cursor_core lldc_checker #(
  .CW ($clog2(DEPTH + 1))
) u_lldc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .count_o        (count_o),
  .cursor_valid_o (cursor_valid_o)
);
